// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the crossfader RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the named reset is asserted.
`define XFD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define XFD_ASSERT(lbl, prop, msg) \
    `XFD_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// File: rtl/xfd_pkg.sv
// ---------------------------------------------------------------------------
// xfd_pkg
// Types, constants and the gain table builder for the equal-power crossfader.
// ---------------------------------------------------------------------------
package xfd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TABLE_LOG2_DEF   = 10;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam int POS_W    = 25;
    localparam int GAIN_W   = 16;
    localparam int CHANS_W  = 5;
    localparam int CFG_CH_W = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int OFIFO_LOG2 = 3;

    localparam logic [POS_W-1:0]    POS_ONE     = 25'h100_0000;
    localparam logic [POS_W-1:0]    STEP_RESET  = 25'd349;
    localparam logic [CFG_CH_W-1:0] CHANS_RESET = 4'd2;
    localparam logic [63:0]         PI_Q30      = 64'd3373259426;

    typedef enum logic [2:0] {
        REQ_START_OUT = 3'd0,
        REQ_START_IN  = 3'd1,
        REQ_RESET     = 3'd2,
        REQ_FADE_OUT  = 3'd3,
        REQ_FADE_IN   = 3'd4,
        REQ_MIX       = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        REG_ENABLE        = 2'd0,
        REG_PHASE_STEP    = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } reg_idx_t;

    // What the datapath does with the sample beat.
    typedef enum logic [2:0] {
        KIND_ZERO     = 3'd0,
        KIND_PASS     = 3'd1,
        KIND_FADE_OUT = 3'd2,
        KIND_FADE_IN  = 3'd3,
        KIND_MIX      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  still_fading;
        logic  done_pulse;
    } xfd_ctl_t;

    function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Q1.15 sine of k*pi/2^(lg+1), Taylor sum in Q30.
    function automatic logic [GAIN_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned lg);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(k) * PI_Q30) >> (lg + 1);
        term = x;
        sum  = x;
        term = taylor_next(term, x) / 64'd6;   sum = sum - term;
        term = taylor_next(term, x) / 64'd20;  sum = sum + term;
        term = taylor_next(term, x) / 64'd42;  sum = sum - term;
        term = taylor_next(term, x) / 64'd72;  sum = sum + term;
        term = taylor_next(term, x) / 64'd110; sum = sum - term;
        term = taylor_next(term, x) / 64'd156; sum = sum + term;
        term = taylor_next(term, x) / 64'd210; sum = sum - term;
        term = taylor_next(term, x) / 64'd272; sum = sum + term;
        sum = (sum + 64'd16384) >> 15;
        if (sum > 64'd32768) begin
            sum = 64'd32768;
        end
        return sum[GAIN_W-1:0];
    endfunction

endpackage

// File: rtl/xfd_rom.sv
// ---------------------------------------------------------------------------
// xfd_rom
// Quarter-sine gain ROM, two registered read ports (sine and cosine).
// ---------------------------------------------------------------------------
module xfd_rom #(
    parameter int TABLE_ENTRIES_LOG2 = xfd_pkg::TABLE_LOG2_DEF
) (
    input  logic                          aclk,
    input  logic                          rd_en_i,
    input  logic [TABLE_ENTRIES_LOG2:0]   idx_i,
    output logic [xfd_pkg::GAIN_W-1:0]    gain_sin_o,
    output logic [xfd_pkg::GAIN_W-1:0]    gain_cos_o
);

    localparam int ROM_DEPTH = (1 << TABLE_ENTRIES_LOG2) + 1;
    localparam logic [TABLE_ENTRIES_LOG2:0] ROM_LAST = 1 << TABLE_ENTRIES_LOG2;

    typedef logic [xfd_pkg::GAIN_W-1:0] rom_arr_t [ROM_DEPTH];

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            t[k] = xfd_pkg::sine_entry(k, TABLE_ENTRIES_LOG2);
        end
        return t;
    endfunction

    localparam rom_arr_t ROM_TABLE = build_rom();

    logic [TABLE_ENTRIES_LOG2:0]   cos_idx;
    logic [xfd_pkg::GAIN_W-1:0]    gain_sin_reg;
    logic [xfd_pkg::GAIN_W-1:0]    gain_cos_reg;

    // cosine of the position is the sine of its mirror
    assign cos_idx = ROM_LAST - idx_i;

    always_ff @(posedge aclk) begin
        if (rd_en_i) begin
            gain_sin_reg <= ROM_TABLE[idx_i];
            gain_cos_reg <= ROM_TABLE[cos_idx];
        end
    end

    assign gain_sin_o = gain_sin_reg;
    assign gain_cos_o = gain_cos_reg;

endmodule

// File: rtl/xfd_ctrl.sv
// ---------------------------------------------------------------------------
// xfd_ctrl
// Fade state, command decode and gain index; first pipeline stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xfd_ctrl #(
    parameter int SAMPLE_WIDTH       = xfd_pkg::SAMPLE_WIDTH_DEF,
    parameter int TABLE_ENTRIES_LOG2 = xfd_pkg::TABLE_LOG2_DEF,
    parameter int MAX_CHANNELS       = xfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept_i,
    input  logic [2:0]                        req_type_i,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_a_i,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_b_i,
    input  logic                              block_end_i,
    input  logic                              cfg_enable_i,
    input  logic [xfd_pkg::POS_W-1:0]         cfg_step_i,
    input  logic [xfd_pkg::CFG_CH_W-1:0]      cfg_chans_i,
    output logic [TABLE_ENTRIES_LOG2:0]       rom_idx_o,
    output logic                              s1_valid_o,
    output xfd_pkg::xfd_ctl_t                 s1_ctl_o,
    output logic signed [SAMPLE_WIDTH-1:0]    s1_a_o,
    output logic signed [SAMPLE_WIDTH-1:0]    s1_b_o
);

    localparam int POS_W = xfd_pkg::POS_W;
    localparam int CH_W  = xfd_pkg::CHANS_W;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam logic [POS_W-1:0] IDX_HALF = POS_W'(1 << (23 - TABLE_ENTRIES_LOG2));

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             active_reg, active_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                           s1_valid_reg;
    xfd_pkg::xfd_ctl_t              s1_ctl_reg, ctl_next;
    logic signed [SAMPLE_WIDTH-1:0] s1_a_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_b_reg;

    logic [POS_W:0]   pos_sum;
    logic [POS_W-1:0] pos_adv;
    logic [POS_W-1:0] pos_frame;
    logic [POS_W-1:0] idx_sum;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_frame;
    logic [CH_W-1:0]  chans;
    logic             frame_end;

    // position after this beat if it closes a frame, clamped at 1.0
    assign pos_sum = {1'b0, pos_reg} + {1'b0, cfg_step_i};
    assign pos_adv = (pos_sum > {1'b0, xfd_pkg::POS_ONE}) ? xfd_pkg::POS_ONE
                                                         : pos_sum[POS_W-1:0];

    always_comb begin
        if (cfg_chans_i == '0) begin
            chans = CH_W'(1);
        end else if ({1'b0, cfg_chans_i} > CH_W'(MAX_CHANNELS)) begin
            chans = CH_W'(MAX_CHANNELS);
        end else begin
            chans = {1'b0, cfg_chans_i};
        end
    end

    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign frame_end = CH_W'(cnt_inc) >= chans;
    assign cnt_frame = frame_end ? '0 : cnt_inc;
    assign pos_frame = frame_end ? pos_adv : pos_reg;

    // round the position to the nearest table entry
    assign idx_sum   = pos_reg + IDX_HALF;
    assign rom_idx_o = idx_sum[POS_W-1 -: TABLE_ENTRIES_LOG2 + 1];

    always_comb begin
        pos_next     = pos_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        ctl_next.kind       = xfd_pkg::KIND_ZERO;
        ctl_next.done_pulse = 1'b0;
        unique case (req_type_i) inside
            xfd_pkg::REQ_START_OUT: begin
                if (cfg_enable_i) begin
                    pending_next = 1'b1;
                    active_next  = 1'b1;
                    pos_next     = '0;
                    cnt_next     = '0;
                end else begin
                    ctl_next.done_pulse = 1'b1;
                end
            end
            xfd_pkg::REQ_START_IN: begin
                if (cfg_enable_i) begin
                    active_next = 1'b1;
                    pos_next    = '0;
                    cnt_next    = '0;
                end
            end
            xfd_pkg::REQ_RESET: begin
                pos_next     = '0;
                active_next  = 1'b0;
                pending_next = 1'b0;
                cnt_next     = '0;
            end
            xfd_pkg::REQ_FADE_OUT, xfd_pkg::REQ_FADE_IN, xfd_pkg::REQ_MIX: begin
                if (!cfg_enable_i || !active_reg) begin
                    ctl_next.kind = xfd_pkg::KIND_PASS;
                end else begin
                    if (req_type_i == xfd_pkg::REQ_FADE_OUT) begin
                        ctl_next.kind = xfd_pkg::KIND_FADE_OUT;
                    end else if (req_type_i == xfd_pkg::REQ_FADE_IN) begin
                        ctl_next.kind = xfd_pkg::KIND_FADE_IN;
                    end else begin
                        ctl_next.kind = xfd_pkg::KIND_MIX;
                    end
                    pos_next = pos_frame;
                    cnt_next = cnt_frame;
                    // stop at a buffer end once the position reached 1.0
                    if (block_end_i && (pos_frame >= xfd_pkg::POS_ONE)) begin
                        active_next = 1'b0;
                        pos_next    = '0;
                        cnt_next    = '0;
                        if ((req_type_i != xfd_pkg::REQ_FADE_IN) && pending_reg) begin
                            ctl_next.done_pulse = 1'b1;
                            pending_next        = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        ctl_next.still_fading = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            active_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept_i;
            if (accept_i) begin
                pos_reg     <= pos_next;
                active_reg  <= active_next;
                pending_reg <= pending_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_i) begin
            s1_ctl_reg <= ctl_next;
            s1_a_reg   <= sample_a_i;
            s1_b_reg   <= sample_b_i;
        end
    end

    assign s1_valid_o = s1_valid_reg;
    assign s1_ctl_o   = s1_ctl_reg;
    assign s1_a_o     = s1_a_reg;
    assign s1_b_o     = s1_b_reg;

    `XFD_ASSERT(a_ctrl_idle_cleared, !active_reg |-> (pos_reg == '0 && cnt_reg == '0), "idle fade with stale position")
    `XFD_ASSERT(a_ctrl_pos_capped, pos_reg <= xfd_pkg::POS_ONE, "fade position above 1.0")

endmodule

// File: rtl/xfd_mac.sv
// ---------------------------------------------------------------------------
// xfd_mac
// Gain multiply, mix sum, rounding and saturation; pipeline stages two, three.
// ---------------------------------------------------------------------------
module xfd_mac #(
    parameter int SAMPLE_WIDTH = xfd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s1_valid_i,
    input  xfd_pkg::xfd_ctl_t                 s1_ctl_i,
    input  logic signed [SAMPLE_WIDTH-1:0]    s1_a_i,
    input  logic signed [SAMPLE_WIDTH-1:0]    s1_b_i,
    input  logic [xfd_pkg::GAIN_W-1:0]        gain_sin_i,
    input  logic [xfd_pkg::GAIN_W-1:0]        gain_cos_i,
    output logic                              res_valid_o,
    output logic [SAMPLE_WIDTH+1:0]           res_data_o
);

    localparam int GW     = xfd_pkg::GAIN_W;
    localparam int PROD_W = SAMPLE_WIDTH + GW + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << 14);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic [GW-1:0]                  gain_a;
    logic signed [PROD_W-1:0]       prod_a_next, prod_b_next;
    logic signed [PROD_W-1:0]       prod_a_reg, prod_b_reg;
    logic                           p2_valid_reg;
    xfd_pkg::xfd_ctl_t              p2_ctl_reg;
    logic signed [SAMPLE_WIDTH-1:0] p2_a_reg;

    logic signed [SUM_W-1:0]        acc_sum;
    logic signed [SUM_W-1:0]        acc_rnd;
    logic [SAMPLE_WIDTH-1:0]        sat_val;
    logic [SAMPLE_WIDTH-1:0]        out_next;
    logic                           res_valid_reg;
    logic [SAMPLE_WIDTH+1:0]        res_data_reg;

    assign gain_a      = (s1_ctl_i.kind == xfd_pkg::KIND_FADE_IN) ? gain_sin_i : gain_cos_i;
    assign prod_a_next = s1_a_i * $signed({1'b0, gain_a});
    // keep both arms signed so a negative B sample extends correctly
    assign prod_b_next = (s1_ctl_i.kind == xfd_pkg::KIND_MIX)
                       ? s1_b_i * $signed({1'b0, gain_sin_i}) : PROD_W'(0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= s1_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_i) begin
            p2_ctl_reg <= s1_ctl_i;
            p2_a_reg   <= s1_a_i;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // round half up with an arithmetic shift, then clamp
    assign acc_sum = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);
    assign acc_rnd = (acc_sum + ROUND_HALF) >>> 15;

    always_comb begin
        if (acc_rnd > SAT_HI) begin
            sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (acc_rnd < SAT_LO) begin
            sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            sat_val = acc_rnd[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        case (p2_ctl_reg.kind) inside
            xfd_pkg::KIND_PASS: begin
                out_next = p2_a_reg;
            end
            xfd_pkg::KIND_FADE_OUT, xfd_pkg::KIND_FADE_IN, xfd_pkg::KIND_MIX: begin
                out_next = sat_val;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_valid_reg) begin
            res_data_reg <= {p2_ctl_reg.done_pulse, p2_ctl_reg.still_fading, out_next};
        end
    end

    assign res_valid_o = res_valid_reg;
    assign res_data_o  = res_data_reg;

endmodule

// File: rtl/xfd_ofifo.sv
// ---------------------------------------------------------------------------
// xfd_ofifo
// Output result queue with credit count that paces input acceptance.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xfd_ofifo #(
    parameter int DATA_W     = xfd_pkg::SAMPLE_WIDTH_DEF + 2,
    parameter int DEPTH_LOG2 = xfd_pkg::OFIFO_LOG2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              claim_i,
    output logic              ready_o,
    input  logic              push_i,
    input  logic [DATA_W-1:0] push_data_i,
    output logic              m_valid_o,
    input  logic              m_ready_i,
    output logic [DATA_W-1:0] m_data_o
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam logic [DEPTH_LOG2:0] DEPTH_CNT = (DEPTH_LOG2 + 1)'(DEPTH);

    logic [DATA_W-1:0]     mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [DEPTH_LOG2:0]   cnt_reg, occ_reg;
    logic                  pop;

    assign m_valid_o = (cnt_reg != '0);
    assign pop       = m_valid_o && m_ready_i;
    assign m_data_o  = mem_reg[rd_ptr_reg];
    // a beat is taken only with a slot reserved for its result
    assign ready_o   = (occ_reg < DEPTH_CNT);

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= push_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            occ_reg    <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + DEPTH_LOG2'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + DEPTH_LOG2'(1);
            end
            case ({push_i, pop})
                2'b10:   cnt_reg <= cnt_reg + (DEPTH_LOG2 + 1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (DEPTH_LOG2 + 1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
            case ({claim_i, pop})
                2'b10:   occ_reg <= occ_reg + (DEPTH_LOG2 + 1)'(1);
                2'b01:   occ_reg <= occ_reg - (DEPTH_LOG2 + 1)'(1);
                default: occ_reg <= occ_reg;
            endcase
        end
    end

    `XFD_ASSERT(a_ofifo_no_overrun, push_i |-> (cnt_reg < DEPTH_CNT), "result queue overrun")
    `XFD_ASSERT(a_ofifo_credit_cover, cnt_reg <= occ_reg, "queued results exceed credits")
    `XFD_ASSERT(a_ofifo_credit_max, occ_reg <= DEPTH_CNT, "credit count above queue depth")

endmodule

// File: rtl/equal_power_crossfader.sv
// ---------------------------------------------------------------------------
// equal_power_crossfader
// Equal-power sine/cosine crossfader for interleaved audio sample streams.
// ---------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat per input beat, in
// order. From input acceptance to m_tvalid a beat passes through state
// update and dual ROM read, gain multiply, sum/round/saturate, then the
// 8-entry result queue. s_tready drops only when eight results are in flight
// or waiting, so a stalled m_tready back-pressures the input after that. Gains
// come from a quarter-sine ROM of 2^TABLE_ENTRIES_LOG2+1 entries read at the
// sine and cosine addresses in the same cycle. Registers (APB, byte address):
// 0x0 enable, 0x4 phase_step (Q1.24), 0x8 channel_count; write them only while
// no beats are outstanding.
module equal_power_crossfader #(
    parameter int SAMPLE_WIDTH       = xfd_pkg::SAMPLE_WIDTH_DEF,
    parameter int TABLE_ENTRIES_LOG2 = xfd_pkg::TABLE_LOG2_DEF,
    parameter int MAX_CHANNELS       = xfd_pkg::MAX_CHANNELS_DEF,
    localparam int IN_TDATA_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TDATA_W-1:0]         s_tdata,   // sample_a, sample_b
    input  logic [2:0]                    s_tuser,   // req_type
    input  logic                          s_tlast,   // block_end
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata,   // sample_out
    output logic [1:0]                    m_tuser,   // still_fading, done_pulse
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [xfd_pkg::DATA_W-1:0]    pwdata,
    output logic [xfd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int RES_W = SAMPLE_WIDTH + 2;

    logic                              enable_reg;
    logic [xfd_pkg::POS_W-1:0]         step_reg;
    logic [xfd_pkg::CFG_CH_W-1:0]      chans_reg;
    logic                              cfg_wr;
    logic [1:0]                        reg_sel;

    logic                              accept;
    logic                              rom_en;
    logic [TABLE_ENTRIES_LOG2:0]       rom_idx;
    logic [xfd_pkg::GAIN_W-1:0]        gain_sin, gain_cos;
    logic                              s1_valid;
    xfd_pkg::xfd_ctl_t                 s1_ctl;
    logic signed [SAMPLE_WIDTH-1:0]    s1_a, s1_b;
    logic                              res_valid;
    logic [RES_W-1:0]                  res_data;
    logic [RES_W-1:0]                  out_data;

    // ---- configuration registers ----
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            step_reg   <= xfd_pkg::STEP_RESET;
            chans_reg  <= xfd_pkg::CHANS_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                xfd_pkg::REG_ENABLE:        enable_reg <= pwdata[0];
                xfd_pkg::REG_PHASE_STEP:    step_reg   <= pwdata[xfd_pkg::POS_W-1:0];
                xfd_pkg::REG_CHANNEL_COUNT: chans_reg  <= pwdata[xfd_pkg::CFG_CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            xfd_pkg::REG_ENABLE:        prdata = xfd_pkg::DATA_W'(enable_reg);
            xfd_pkg::REG_PHASE_STEP:    prdata = xfd_pkg::DATA_W'(step_reg);
            xfd_pkg::REG_CHANNEL_COUNT: prdata = xfd_pkg::DATA_W'(chans_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---- datapath ----
    assign accept = s_tvalid && s_tready;
    assign rom_en = accept;

    xfd_ctrl #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .TABLE_ENTRIES_LOG2 (TABLE_ENTRIES_LOG2),
        .MAX_CHANNELS       (MAX_CHANNELS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_i     (accept),
        .req_type_i   (s_tuser),
        .sample_a_i   (s_tdata[SAMPLE_WIDTH-1:0]),
        .sample_b_i   (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .block_end_i  (s_tlast),
        .cfg_enable_i (enable_reg),
        .cfg_step_i   (step_reg),
        .cfg_chans_i  (chans_reg),
        .rom_idx_o    (rom_idx),
        .s1_valid_o   (s1_valid),
        .s1_ctl_o     (s1_ctl),
        .s1_a_o       (s1_a),
        .s1_b_o       (s1_b)
    );

    xfd_rom #(
        .TABLE_ENTRIES_LOG2 (TABLE_ENTRIES_LOG2)
    ) u_rom (
        .aclk       (aclk),
        .rd_en_i    (rom_en),
        .idx_i      (rom_idx),
        .gain_sin_o (gain_sin),
        .gain_cos_o (gain_cos)
    );

    xfd_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid_i  (s1_valid),
        .s1_ctl_i    (s1_ctl),
        .s1_a_i      (s1_a),
        .s1_b_i      (s1_b),
        .gain_sin_i  (gain_sin),
        .gain_cos_i  (gain_cos),
        .res_valid_o (res_valid),
        .res_data_o  (res_data)
    );

    xfd_ofifo #(
        .DATA_W     (RES_W),
        .DEPTH_LOG2 (xfd_pkg::OFIFO_LOG2)
    ) u_ofifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .claim_i     (accept),
        .ready_o     (s_tready),
        .push_i      (res_valid),
        .push_data_i (res_data),
        .m_valid_o   (m_tvalid),
        .m_ready_i   (m_tready),
        .m_data_o    (out_data)
    );

    assign m_tdata = OUT_TDATA_W'(out_data[SAMPLE_WIDTH-1:0]);
    assign m_tuser = out_data[RES_W-1:SAMPLE_WIDTH];

endmodule
